### sv/ptst_pkg.sv
// Shared types and codes for the periodic timer slot table.
// Used by ptst_ram users and by periodic_timer_slot_table_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ptst_pkg;

  typedef enum logic [2:0] {
    ACT_ADD      = 3'd0,
    ACT_DELETE   = 3'd1,
    ACT_PAUSE    = 3'd2,
    ACT_CONTINUE = 3'd3,
    ACT_REFRESH  = 3'd4,
    ACT_SET_IVAL = 3'd5,
    ACT_EXECUTE  = 3'd6,
    ACT_NOP      = 3'd7
  } action_t;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_FIRED = 2'd3;

  // One slot's stored record; the active mark lives in flip-flops.
  typedef struct packed {
    logic        paused;
    logic [31:0] interval;
    logic [31:0] last_fire;
    logic [15:0] id;
    logic [7:0]  tag;
  } slot_rec_t;

endpackage

`default_nettype wire

### sv/periodic_timer_slot_table_unit.sv
// Top level of the periodic timer slot table: sequencer, active marks and id counter.
// Depends on ptst_pkg and ptst_ram (slot record store).
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one command beat: action, timer id,
//    interval, handler tag and the current millisecond time.
//  - Result channel (out_valid/out_ready) returns one beat per result; out_last marks
//    the final beat of a command. Execute returns one beat per firing slot, in slot
//    order, or a single done beat when nothing fires.
//  - Add claims the lowest free slot or reports full. Lookups (delete, pause,
//    continue, refresh, set interval) and execute walk the slots one at a time through
//    the single record RAM read port: an inactive slot is skipped, an active slot is
//    read (S_READ), then compared or updated (S_EVAL); the result goes out via S_EMIT.
//    in_ready is high only between commands.
//  - Reset clears every active mark and the id counter; the record store needs no
//    clearing since a record is only read once its slot has been added.
//  - A stalled receiver holds the result register; the walk pauses at a firing slot
//    until the previous fire beat has gone, so no beat is lost.
`timescale 1ns / 1ps
`default_nettype none

module periodic_timer_slot_table_unit
  import ptst_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_action,
  input  wire logic [15:0] in_timer_id,
  input  wire logic [31:0] in_interval,
  input  wire logic [7:0]  in_handler_tag,
  input  wire logic [31:0] in_now_time,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [15:0]      out_result_id,
  output logic [7:0]       out_fired_tag,
  output logic             out_last
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RW = $bits(slot_rec_t);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ADD  = 5'b00010,
    S_READ = 5'b00100,
    S_EVAL = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Control state
  logic [SLOTS-1:0] active_r, active_nxt;
  logic [15:0]      idcnt_r, idcnt_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload registers
  action_t     act_r, act_nxt;
  logic [15:0] id_r, id_nxt;
  logic [31:0] ival_r, ival_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [31:0] now_r, now_nxt;
  logic [15:0] pend_id_r, pend_id_nxt;
  logic [7:0]  pend_tag_r, pend_tag_nxt;
  logic [1:0]  res_status_r, res_status_nxt;
  logic [15:0] res_id_r, res_id_nxt;
  logic [7:0]  res_tag_r, res_tag_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [15:0] out_id_r, out_id_nxt;
  logic [7:0]  out_tag_r, out_tag_nxt;
  logic        out_last_r, out_last_nxt;

  // Record store
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr;
  slot_rec_t     ram_wdata, rec;
  logic [RW-1:0] ram_rdata;

  // Free slot search and shared compare unit
  logic [IW-1:0] free_idx;
  logic          free_any;
  logic [15:0]   idcnt_inc;
  logic [31:0]   elapsed;
  logic          fire;
  logic          out_free;
  logic          step;

  ptst_ram #(
    .WIDTH (RW),
    .DEPTH (SLOTS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign rec = slot_rec_t'(ram_rdata);

  // Lowest free slot
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_idx = IW'(i);
        free_any = 1'b1;
      end
    end
  end

  // Next id skips zero
  assign idcnt_inc = (idcnt_r == 16'hFFFF) ? 16'd1 : idcnt_r + 16'd1;

  // Modular elapsed time against the interval
  assign elapsed = now_r - rec.last_fire;
  assign fire    = !rec.paused && (elapsed >= rec.interval);

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt      = state_r;
    active_nxt     = active_r;
    idcnt_nxt      = idcnt_r;
    idx_nxt        = idx_r;
    pend_v_nxt     = pend_v_r;
    pend_id_nxt    = pend_id_r;
    pend_tag_nxt   = pend_tag_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_tag_nxt    = res_tag_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_tag_nxt    = out_tag_r;
    out_last_nxt   = out_last_r;
    act_nxt        = act_r;
    id_nxt         = id_r;
    ival_nxt       = ival_r;
    tag_nxt        = tag_r;
    now_nxt        = now_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = rec;
    step           = 1'b0;

    // Drop the result beat once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt    = action_t'(in_action);
          id_nxt     = in_timer_id;
          ival_nxt   = in_interval;
          tag_nxt    = in_handler_tag;
          now_nxt    = in_now_time;
          idx_nxt    = '0;
          pend_v_nxt = 1'b0;
          case (action_t'(in_action))
            ACT_ADD: state_nxt = S_ADD;
            ACT_NOP: begin
              res_status_nxt = ST_DONE;
              res_id_nxt     = '0;
              res_tag_nxt    = '0;
              state_nxt      = S_EMIT;
            end
            default: state_nxt = S_READ;
          endcase
        end
      end

      S_ADD: begin
        res_tag_nxt = '0;
        if (!free_any) begin
          res_status_nxt = ST_FULL;
          res_id_nxt     = '0;
        end else begin
          ram_we               = 1'b1;
          ram_waddr            = free_idx;
          ram_wdata.paused     = 1'b0;
          ram_wdata.interval   = ival_r;
          ram_wdata.last_fire  = now_r;
          ram_wdata.id         = idcnt_inc;
          ram_wdata.tag        = tag_r;
          active_nxt[free_idx] = 1'b1;
          idcnt_nxt            = idcnt_inc;
          res_status_nxt       = ST_DONE;
          res_id_nxt           = idcnt_inc;
        end
        state_nxt = S_EMIT;
      end

      S_READ: begin
        // Skip inactive slots without touching the store
        if (active_r[idx_r]) begin
          ram_re    = 1'b1;
          state_nxt = S_EVAL;
        end else begin
          step = 1'b1;
        end
      end

      S_EVAL: begin
        if (act_r == ACT_EXECUTE) begin
          if (!fire) begin
            step = 1'b1;
          end else if (!pend_v_r || out_free) begin
            // Restamp, flush the previous fire beat and hold this one back
            ram_we              = 1'b1;
            ram_wdata.last_fire = now_r;
            if (pend_v_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_FIRED;
              out_id_nxt     = pend_id_r;
              out_tag_nxt    = pend_tag_r;
              out_last_nxt   = 1'b0;
            end
            pend_v_nxt   = 1'b1;
            pend_id_nxt  = rec.id;
            pend_tag_nxt = rec.tag;
            step         = 1'b1;
          end
        end else if (rec.id == id_r) begin
          case (act_r)
            ACT_DELETE: active_nxt[idx_r] = 1'b0;
            ACT_PAUSE: begin
              ram_we           = 1'b1;
              ram_wdata.paused = 1'b1;
            end
            ACT_CONTINUE: begin
              ram_we              = 1'b1;
              ram_wdata.paused    = 1'b0;
              ram_wdata.last_fire = now_r;
            end
            ACT_REFRESH: begin
              ram_we              = 1'b1;
              ram_wdata.last_fire = now_r;
            end
            default: begin
              ram_we              = 1'b1;
              ram_wdata.interval  = ival_r;
              ram_wdata.last_fire = now_r;
            end
          endcase
          res_status_nxt = ST_DONE;
          res_id_nxt     = '0;
          res_tag_nxt    = '0;
          state_nxt      = S_EMIT;
        end else begin
          step = 1'b1;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          out_tag_nxt    = res_tag_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // Advance the walk, or close it at the last slot
    if (step) begin
      if (idx_r == LAST_IDX) begin
        if (act_r == ACT_EXECUTE) begin
          if (pend_v_nxt) begin
            res_status_nxt = ST_FIRED;
            res_id_nxt     = pend_id_nxt;
            res_tag_nxt    = pend_tag_nxt;
          end else begin
            res_status_nxt = ST_DONE;
            res_id_nxt     = '0;
            res_tag_nxt    = '0;
          end
        end else begin
          res_status_nxt = ST_NONE;
          res_id_nxt     = '0;
          res_tag_nxt    = '0;
        end
        state_nxt = S_EMIT;
      end else begin
        idx_nxt   = idx_r + IW'(1);
        state_nxt = S_READ;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      idcnt_r     <= '0;
      idx_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      idcnt_r     <= idcnt_nxt;
      idx_r       <= idx_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    id_r         <= id_nxt;
    ival_r       <= ival_nxt;
    tag_r        <= tag_nxt;
    now_r        <= now_nxt;
    pend_id_r    <= pend_id_nxt;
    pend_tag_r   <= pend_tag_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_tag_r    <= res_tag_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_tag_r    <= out_tag_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_result_id = out_id_r;
  assign out_fired_tag = out_tag_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

### sv/ptst_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ptst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
